/* src/nmea_gga_field_extractor_defines.svh */
// Assertion macros shared by the NMEA GGA field extractor checker.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef NMEA_GGA_FIELD_EXTRACTOR_DEFINES_SVH
`define NMEA_GGA_FIELD_EXTRACTOR_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define NGFE_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ngfe check failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define NGFE_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ngfe check failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define NGFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ngfe check failed");

`endif

/* src/ngfe_pkg.sv */
// Package for the NMEA GGA field extractor: result kinds, register
// indexes, character codes and the result word type. No dependencies.
package ngfe_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_END  = 2'd1,
		KIND_NONE = 2'd2
	} kind_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_LINES = 2'd0,
		REG_FIRST = 2'd1,
		REG_FINAL = 2'd2
	} reg_idx_t;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// Register reset values
	localparam logic [3:0] LINES_RESET = 4'd9;
	localparam logic [3:0] FIRST_RESET = 4'd2;
	localparam logic [3:0] FINAL_RESET = 4'd5;

	// Saturation limits of the line counters and header character positions
	localparam logic [2:0] POS_MAX   = 3'd6;
	localparam logic [2:0] POS_HDR0  = 3'd3;
	localparam logic [2:0] POS_HDR1  = 3'd4;
	localparam logic [2:0] POS_HDR2  = 3'd5;
	localparam logic [3:0] COMMA_MAX = 4'd15;

	// Character codes
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	// One result word
	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic [3:0] idx;
		logic       last;
	} res_t;

endpackage

/* src/nmea_gga_field_extractor.sv */
// Top level of the NMEA GGA field extractor: byte parser, output register
// with skid stage, APB register file. Depends on ngfe_pkg.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  rx_byte
// result    out        out_valid/out_ready  kind, char_out, field_index, last
// config    in (APB)   psel/penable/pready  paddr, pwdata, prdata
//
// One byte is accepted per cycle while in_ready is high. Its result (if any)
// is registered in the output word, or parked in the skid stage on a stall;
// parser state advances in the same cycle the byte is taken. in_ready drops
// only while the skid stage is full. arst_n clears all control state.
module nmea_gga_field_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  char_out,
	output logic [3:0]  field_index,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [ngfe_pkg::PADDR_W-1:0] paddr,
	input  logic [ngfe_pkg::PDATA_W-1:0] pwdata,
	output logic [ngfe_pkg::PDATA_W-1:0] prdata,
	output logic        pready
);

	// Configuration registers
	logic [3:0] lines_q, first_q, final_q;
	// Parser state
	logic [3:0] line_count_q;
	logic [2:0] char_pos_q;
	logic       hdr_match_q;
	logic [3:0] comma_count_q;
	logic       found_q;
	logic       capturing_q;
	// Output and skid stages
	logic            out_valid_q, skid_valid_q;
	ngfe_pkg::res_t  out_q, skid_q;

	// Next-state and result of the current byte
	logic [3:0] line_count_d;
	logic [2:0] char_pos_d;
	logic       hdr_match_d;
	logic [3:0] comma_count_d;
	logic       found_d;
	logic       capturing_d;
	logic            res_valid;
	ngfe_pkg::res_t  res;
	logic [3:0] limit;
	logic [4:0] next_line;
	logic       in_range;
	logic       accept;
	logic       cfg_wr;
	ngfe_pkg::reg_idx_t reg_idx;

	assign accept = in_valid && in_ready;
	assign in_ready = !skid_valid_q;

	// Parse one byte
	always_comb begin
		line_count_d  = line_count_q;
		char_pos_d    = char_pos_q;
		hdr_match_d   = hdr_match_q;
		comma_count_d = comma_count_q;
		found_d       = found_q;
		capturing_d   = capturing_q;
		res_valid     = 1'b0;
		res.kind      = ngfe_pkg::KIND_END;
		res.ch        = 8'd0;
		res.idx       = comma_count_q;
		res.last      = 1'b1;
		limit         = (lines_q == 4'd0) ? 4'd1 : lines_q;
		next_line     = {1'b0, line_count_q} + 5'd1;
		in_range      = (comma_count_q >= first_q) && (comma_count_q <= final_q);

		if (rx_byte == ngfe_pkg::CH_LF) begin
			// Line end: force field end, reset line state, maybe close group
			if (capturing_q) begin
				res_valid   = 1'b1;
				capturing_d = 1'b0;
			end
			char_pos_d    = 3'd0;
			hdr_match_d   = 1'b0;
			comma_count_d = 4'd0;
			if (next_line >= {1'b0, limit}) begin
				if (!found_q) begin
					res_valid = 1'b1;
					res.kind  = ngfe_pkg::KIND_NONE;
					res.idx   = 4'd0;
				end
				line_count_d = 4'd0;
				found_d      = 1'b0;
			end else begin
				line_count_d = next_line[3:0];
			end
		end else begin
			if (capturing_q) begin
				// Emit characters and field ends of the chosen sentence
				if (rx_byte == ngfe_pkg::CH_CR) begin
					res_valid   = 1'b1;
					capturing_d = 1'b0;
				end else if (rx_byte == ngfe_pkg::CH_COMMA) begin
					if (in_range) begin
						res_valid = 1'b1;
						res.last  = (comma_count_q == final_q);
						if (comma_count_q == final_q) begin
							capturing_d = 1'b0;
						end
					end
				end else if (in_range) begin
					res_valid = 1'b1;
					res.kind  = ngfe_pkg::KIND_CHAR;
					res.ch    = rx_byte;
					res.last  = 1'b0;
				end
			end else if (char_pos_q == ngfe_pkg::POS_HDR0) begin
				hdr_match_d = (rx_byte == ngfe_pkg::CH_G);
			end else if (char_pos_q == ngfe_pkg::POS_HDR1) begin
				hdr_match_d = hdr_match_q && (rx_byte == ngfe_pkg::CH_G);
			end else if (char_pos_q == ngfe_pkg::POS_HDR2) begin
				// Choose the first GGA line of the group
				if (hdr_match_q && (rx_byte == ngfe_pkg::CH_A) && !found_q) begin
					found_d     = 1'b1;
					capturing_d = 1'b1;
				end
				hdr_match_d = 1'b0;
			end
			if ((rx_byte == ngfe_pkg::CH_COMMA) && (comma_count_q < ngfe_pkg::COMMA_MAX)) begin
				comma_count_d = comma_count_q + 4'd1;
			end
			if (char_pos_q < ngfe_pkg::POS_MAX) begin
				char_pos_d = char_pos_q + 3'd1;
			end
		end
	end

	// Advance parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q  <= 4'd0;
			char_pos_q    <= 3'd0;
			hdr_match_q   <= 1'b0;
			comma_count_q <= 4'd0;
			found_q       <= 1'b0;
			capturing_q   <= 1'b0;
		end else if (accept) begin
			line_count_q  <= line_count_d;
			char_pos_q    <= char_pos_d;
			hdr_match_q   <= hdr_match_d;
			comma_count_q <= comma_count_d;
			found_q       <= found_d;
			capturing_q   <= capturing_d;
		end
	end

	// Output register with skid stage: hold on stall, drain skid first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept && res_valid;
			end
		end else if (accept && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign char_out    = out_q.ch;
	assign field_index = out_q.idx;
	assign last        = out_q.last;

	// Register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = ngfe_pkg::reg_idx_t'(paddr[ngfe_pkg::PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= ngfe_pkg::LINES_RESET;
			first_q <= ngfe_pkg::FIRST_RESET;
			final_q <= ngfe_pkg::FINAL_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				ngfe_pkg::REG_LINES: lines_q <= pwdata[3:0];
				ngfe_pkg::REG_FIRST: first_q <= pwdata[3:0];
				ngfe_pkg::REG_FINAL: final_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = '0;
		case (reg_idx)
			ngfe_pkg::REG_LINES: prdata[3:0] = lines_q;
			ngfe_pkg::REG_FIRST: prdata[3:0] = first_q;
			ngfe_pkg::REG_FINAL: prdata[3:0] = final_q;
			default: prdata = '0;
		endcase
	end

endmodule

/* src/ngfe_checker.sv */
// Port-level checker for the NMEA GGA field extractor and its bind.
// Depends on ngfe_pkg and nmea_gga_field_extractor_defines.svh.
`include "nmea_gga_field_extractor_defines.svh"

module ngfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  char_out,
	input logic [3:0]  field_index,
	input logic        last
);

	// A none-found word carries last, field zero and no character
	`NGFE_ASSERT_IMPLY(a_none_shape, out_valid && (kind == ngfe_pkg::KIND_NONE), last && (field_index == 4'd0) && (char_out == 8'd0))

	// Only character words carry a character
	`NGFE_ASSERT_IMPLY(a_char_zero, out_valid && (kind != ngfe_pkg::KIND_CHAR), char_out == 8'd0)

	// Input back-pressure only arises behind a stalled output word
	`NGFE_ASSERT_IMPLY(a_stall_cause, !in_ready, out_valid)

	// A stalled output word holds
	`NGFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(char_out) && $stable(field_index) && $stable(last))

endmodule

bind nmea_gga_field_extractor ngfe_checker u_ngfe_checker (.*);

/* tb/testbench.sv */
// Testbench for the NMEA GGA field extractor: streams received bytes,
// writes and reads back the APB registers, and checks every output word.
// Depends on ngfe_pkg and the nmea_gga_field_extractor top level.
module testbench;

	localparam int WAIT_LIMIT   = 1000;
	localparam int SETTLE_TICKS = 8;
	localparam int PHASE_BYTES  = 210;
	localparam int PHASES       = 8;

	localparam logic [7:0]     CH_DOLLAR = 8'h24;
	localparam logic [7:0]     CH_B      = 8'h42;
	localparam ngfe_pkg::res_t NO_WORD   = '0;

	// One row of the directed byte sequence; typed rows carry their own answer
	typedef struct {
		logic [7:0]     b;
		bit             typed;
		bit             has;
		ngfe_pkg::res_t r;
	} plan_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid;
	logic                          in_ready;
	logic [7:0]                    rx_byte;
	logic                          out_valid;
	logic                          out_ready;
	logic [1:0]                    kind;
	logic [7:0]                    char_out;
	logic [3:0]                    field_index;
	logic                          last;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ngfe_pkg::PADDR_W-1:0]  paddr;
	logic [ngfe_pkg::PDATA_W-1:0]  pwdata;
	logic [ngfe_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;

	// Register copies and parser state of the prediction
	logic [3:0] lines_set = ngfe_pkg::LINES_RESET;
	logic [3:0] first_set = ngfe_pkg::FIRST_RESET;
	logic [3:0] final_set = ngfe_pkg::FINAL_RESET;
	logic [3:0] line_cnt = '0;
	logic [2:0] char_pos = '0;
	bit         hdr_ok = 1'b0;
	logic [3:0] commas = '0;
	bit         group_found = 1'b0;
	bit         in_capture = 1'b0;

	ngfe_pkg::res_t pending_fields[$];
	logic [7:0]     line_q[$];
	ngfe_pkg::res_t want;
	int             bad_count = 0;
	int             idle_cycles = 0;
	bit             calm = 1'b0;

	logic [3:0] phase_cfg [PHASES][3] = '{
		'{4'd9, 4'd2, 4'd5}, '{4'd1, 4'd0, 4'd15}, '{4'd15, 4'd15, 4'd15},
		'{4'd0, 4'd0, 4'd0}, '{4'd3, 4'd7, 4'd3}, '{4'd4, 4'd4, 4'd9},
		'{4'd15, 4'd0, 4'd0}, '{4'd5, 4'd1, 4'd6}
	};

	// Directed sequence, run with 2 lines per group and fields 1 to 2
	plan_row_t plan [25] = '{
		'{CH_DOLLAR, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_G, 1'b0, 1'b0, NO_WORD},
		'{8'h50, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_G, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_G, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_A, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_COMMA, 1'b0, 1'b0, NO_WORD},
		'{8'h31, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_COMMA, 1'b0, 1'b0, NO_WORD},
		'{8'h4E, 1'b0, 1'b0, NO_WORD},
		// end of the final field closes the capture
		'{ngfe_pkg::CH_COMMA, 1'b1, 1'b1,
			ngfe_pkg::res_t'{ngfe_pkg::KIND_END, 8'h00, 4'd2, 1'b1}},
		'{8'h78, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_CR, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_LF, 1'b0, 1'b0, NO_WORD},
		// group closes with a sentence found: no word
		'{ngfe_pkg::CH_LF, 1'b1, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_LF, 1'b0, 1'b0, NO_WORD},
		// empty group
		'{ngfe_pkg::CH_LF, 1'b1, 1'b1,
			ngfe_pkg::res_t'{ngfe_pkg::KIND_NONE, 8'h00, 4'd0, 1'b1}},
		'{8'hFF, 1'b0, 1'b0, NO_WORD},
		'{8'h00, 1'b0, 1'b0, NO_WORD},
		'{8'h78, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_G, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_G, 1'b0, 1'b0, NO_WORD},
		'{ngfe_pkg::CH_A, 1'b0, 1'b0, NO_WORD},
		// carriage return forces an end on a field outside the range
		'{ngfe_pkg::CH_CR, 1'b1, 1'b1,
			ngfe_pkg::res_t'{ngfe_pkg::KIND_END, 8'h00, 4'd0, 1'b1}},
		'{ngfe_pkg::CH_LF, 1'b0, 1'b0, NO_WORD}
	};

	nmea_gga_field_extractor uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.char_out    (char_out),
		.field_index (field_index),
		.last        (last),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #4 clk = ~clk;

	function automatic ngfe_pkg::res_t word_of(ngfe_pkg::kind_t k, logic [7:0] c,
			logic [3:0] i, logic l);
		ngfe_pkg::res_t w;
		w.kind = k;
		w.ch   = c;
		w.idx  = i;
		w.last = l;
		return w;
	endfunction

	// Advance the parser copy by one byte; return 1 when it yields a word
	function automatic bit parse_byte(input logic [7:0] c, output ngfe_pkg::res_t w);
		logic [3:0] limit;
		logic [4:0] nxt;
		bit got;
		bit in_rng;
		got = 1'b0;
		w = NO_WORD;
		if (c == ngfe_pkg::CH_LF) begin
			limit = (lines_set == 4'd0) ? 4'd1 : lines_set;
			nxt = {1'b0, line_cnt} + 5'd1;
			if (in_capture) begin
				got = 1'b1;
				w = word_of(ngfe_pkg::KIND_END, 8'h00, commas, 1'b1);
				in_capture = 1'b0;
			end
			char_pos = '0;
			hdr_ok = 1'b0;
			commas = '0;
			if (nxt >= {1'b0, limit}) begin
				if (!group_found) begin
					got = 1'b1;
					w = word_of(ngfe_pkg::KIND_NONE, 8'h00, 4'd0, 1'b1);
				end
				line_cnt = '0;
				group_found = 1'b0;
			end else begin
				line_cnt = nxt[3:0];
			end
			return got;
		end
		if (in_capture) begin
			in_rng = (commas >= first_set) && (commas <= final_set);
			if (c == ngfe_pkg::CH_CR) begin
				got = 1'b1;
				w = word_of(ngfe_pkg::KIND_END, 8'h00, commas, 1'b1);
				in_capture = 1'b0;
			end else if (c == ngfe_pkg::CH_COMMA) begin
				if (in_rng) begin
					got = 1'b1;
					w = word_of(ngfe_pkg::KIND_END, 8'h00, commas, commas == final_set);
					if (commas == final_set)
						in_capture = 1'b0;
				end
			end else if (in_rng) begin
				got = 1'b1;
				w = word_of(ngfe_pkg::KIND_CHAR, c, commas, 1'b0);
			end
		end else if (char_pos == ngfe_pkg::POS_HDR0) begin
			hdr_ok = (c == ngfe_pkg::CH_G);
		end else if (char_pos == ngfe_pkg::POS_HDR1) begin
			hdr_ok = hdr_ok && (c == ngfe_pkg::CH_G);
		end else if (char_pos == ngfe_pkg::POS_HDR2) begin
			if (hdr_ok && c == ngfe_pkg::CH_A && !group_found) begin
				group_found = 1'b1;
				in_capture = 1'b1;
			end
			hdr_ok = 1'b0;
		end
		if (c == ngfe_pkg::CH_COMMA && commas < ngfe_pkg::COMMA_MAX)
			commas = commas + 4'd1;
		if (char_pos < ngfe_pkg::POS_MAX)
			char_pos = char_pos + 3'd1;
		return got;
	endfunction

	function automatic bit count_bad();
		bad_count++;
		return bad_count <= 10;
	endfunction

	// Any byte but a line end, a carriage return or a comma, mostly printable
	function automatic logic [7:0] field_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(99) < 80)
				c = 8'($urandom_range(126, 32));
			else
				c = 8'($urandom_range(255));
		end while (c == ngfe_pkg::CH_LF || c == ngfe_pkg::CH_CR ||
			c == ngfe_pkg::CH_COMMA);
		return c;
	endfunction

	// Append one line: GGA sentence, other or near-miss header, short line or noise
	task automatic add_line();
		int pick;
		int nf;
		int len;
		logic [7:0] h[3];
		pick = $urandom_range(99);
		if (pick < 75) begin
			line_q.push_back(CH_DOLLAR);
			line_q.push_back(field_char());
			line_q.push_back(field_char());
			if (pick < 60) begin
				h = '{ngfe_pkg::CH_G, ngfe_pkg::CH_G, ngfe_pkg::CH_A};
			end else begin
				foreach (h[i]) begin
					case ($urandom_range(2))
						0: h[i] = ngfe_pkg::CH_G;
						1: h[i] = ngfe_pkg::CH_A;
						default: h[i] = field_char();
					endcase
				end
				if (h[0] == ngfe_pkg::CH_G && h[1] == ngfe_pkg::CH_G &&
						h[2] == ngfe_pkg::CH_A)
					h[2] = CH_B;
			end
			foreach (h[i])
				line_q.push_back(h[i]);
			nf = $urandom_range(18);
			repeat (nf) begin
				line_q.push_back(ngfe_pkg::CH_COMMA);
				len = $urandom_range(4);
				repeat (len)
					line_q.push_back(field_char());
			end
			if ($urandom_range(99) < 85)
				line_q.push_back(ngfe_pkg::CH_CR);
		end else if (pick < 85) begin
			len = $urandom_range(5);
			repeat (len)
				line_q.push_back(field_char());
		end else begin
			len = $urandom_range(12, 1);
			repeat (len)
				line_q.push_back(8'($urandom_range(255)));
		end
		line_q.push_back(ngfe_pkg::CH_LF);
	endtask

	// Offer one byte, hold it until taken, then queue its expected word
	task automatic send_byte(input logic [7:0] b, input bit typed, input bit has,
			input ngfe_pkg::res_t r);
		ngfe_pkg::res_t w;
		bit got;
		if (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!calm && $urandom_range(99) < 17);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		got = parse_byte(b, w);
		if (typed) begin
			got = has;
			w = r;
		end
		if (got)
			pending_fields.push_back(w);
	endtask

	task automatic reg_read(input ngfe_pkg::reg_idx_t idx, input logic [3:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ngfe_pkg::PADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== ngfe_pkg::PDATA_W'(v) && count_bad())
			$display("register %0d read: expected %h, got %h", idx,
				ngfe_pkg::PDATA_W'(v), prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write one register, update the copy, then read it back
	task automatic reg_write(input ngfe_pkg::reg_idx_t idx, input logic [3:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ngfe_pkg::PADDR_W'({idx, 2'b00});
		pwdata <= ngfe_pkg::PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			ngfe_pkg::REG_LINES: lines_set = v;
			ngfe_pkg::REG_FIRST: first_set = v;
			default:             final_set = v;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		reg_read(idx, v);
	endtask

	// Wait for all expected words, then let the pipeline run dry
	task automatic settle();
		while (pending_fields.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Stall the output side at random, except in the calm phase
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 17);

	// Check each accepted output word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_fields.size() == 0) begin
				if (count_bad())
					$display("unexpected word: kind %0d char %h field %0d last %0d",
						kind, char_out, field_index, last);
			end else begin
				want = pending_fields.pop_front();
				if ((kind !== want.kind || char_out !== want.ch ||
						field_index !== want.idx || last !== want.last) && count_bad())
					$display("word mismatch: expected kind %0d char %h field %0d last %0d, got kind %0d char %h field %0d last %0d",
						want.kind, want.ch, want.idx, want.last,
						kind, char_out, field_index, last);
			end
		end
	end

	// Stop the run when no channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WAIT_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		in_valid = 1'b0;
		rx_byte = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, then the directed setting
		reg_read(ngfe_pkg::REG_LINES, ngfe_pkg::LINES_RESET);
		reg_read(ngfe_pkg::REG_FIRST, ngfe_pkg::FIRST_RESET);
		reg_read(ngfe_pkg::REG_FINAL, ngfe_pkg::FINAL_RESET);
		reg_write(ngfe_pkg::REG_LINES, 4'd2);
		reg_write(ngfe_pkg::REG_FIRST, 4'd1);
		reg_write(ngfe_pkg::REG_FINAL, 4'd2);
		foreach (plan[i])
			send_byte(plan[i].b, plan[i].typed, plan[i].has, plan[i].r);
		in_valid <= 1'b0;
		settle();

		// Random sentence streams under several register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			calm = (ph == 2);
			if (ph == PHASES - 1)
				for (int k = 0; k < 3; k++)
					phase_cfg[ph][k] = 4'($urandom_range(15));
			reg_write(ngfe_pkg::REG_LINES, phase_cfg[ph][0]);
			reg_write(ngfe_pkg::REG_FIRST, phase_cfg[ph][1]);
			reg_write(ngfe_pkg::REG_FINAL, phase_cfg[ph][2]);
			line_q.delete();
			while (line_q.size() < PHASE_BYTES)
				add_line();
			foreach (line_q[j])
				send_byte(line_q[j], 1'b0, 1'b0, NO_WORD);
			in_valid <= 1'b0;
			settle();
		end

		if (bad_count == 0 && pending_fields.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/ngfe_pkg.sv
src/nmea_gga_field_extractor.sv
src/ngfe_checker.sv
tb/testbench.sv
